// ----- sv/io_request_latency_tracker_macros.svh -----
// Assertion helpers for the latency tracker
`ifndef IO_REQUEST_LATENCY_TRACKER_MACROS_SVH
`define IO_REQUEST_LATENCY_TRACKER_MACROS_SVH

`define IOLT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iolt check failed");

`define IOLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iolt check failed");

`endif

// ----- sv/iolt_pkg.sv -----
package iolt_pkg;

   localparam int TRACK_ENTRIES_DEFAULT = 64;
   localparam int THRESH_W = 40;

   localparam logic [1:0] CMD_EVENT = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_FLUSH = 2'd3;

   localparam logic [1:0] STAGE_GETRQ    = 2'd0;
   localparam logic [1:0] STAGE_INSERT   = 2'd1;
   localparam logic [1:0] STAGE_ISSUE    = 2'd2;
   localparam logic [1:0] STAGE_COMPLETE = 2'd3;

   localparam logic [2:0] ANOM_NONE    = 3'd0;
   localparam logic [2:0] ANOM_EXIST   = 3'd1;
   localparam logic [2:0] ANOM_BYPASS  = 3'd2;
   localparam logic [2:0] ANOM_LOST    = 3'd3;
   localparam logic [2:0] ANOM_GREATER = 3'd4;

   localparam logic [63:0] ALL_ONES = '1;

   typedef struct packed {
      logic        is_event;
      logic [1:0]  command;
      logic [1:0]  stage;
      logic [31:0] device;
      logic [63:0] sector;
      logic [31:0] sector_count;
      logic [63:0] timestamp;
   } item_type;

endpackage

// ----- sv/iolt_ram.sv -----
module iolt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/iolt_front.sv -----
module iolt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [1:0]         req_stage,
   input  logic [31:0]        req_device,
   input  logic [63:0]        req_sector,
   input  logic [31:0]        req_sector_count,
   input  logic [63:0]        req_timestamp,
   output logic               q_valid,
   output iolt_pkg::item_type q_item,
   input  logic               q_pop
);
   import iolt_pkg::*;

   logic [1:0] count_ff, count_in;
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   item_type   slot_ff [2];
   item_type   incoming;
   logic       push;

   always_comb begin
      incoming.is_event     = (req_command == CMD_EVENT) && (req_sector != ALL_ONES);
      incoming.command      = req_command;
      incoming.stage        = req_stage;
      incoming.device       = req_device;
      incoming.sector       = req_sector;
      incoming.sector_count = req_sector_count;
      incoming.timestamp    = req_timestamp;
   end

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[head_ff];

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push) begin
         tail_in = !tail_ff;
      end
      if (q_pop) begin
         head_in = !head_ff;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= incoming;
      end
   end
endmodule

// ----- sv/iolt_back.sv -----
module iolt_back #(
   parameter int TRACK_ENTRIES = iolt_pkg::TRACK_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [iolt_pkg::THRESH_W-1:0]  threshold,
   input  logic                           q_valid,
   input  iolt_pkg::item_type             q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   output logic                           rsp_matched,
   output logic [2:0]                     rsp_anomaly,
   output logic [63:0]                    rsp_delay,
   output logic [63:0]                    rsp_stat_count,
   output logic [63:0]                    rsp_stat_sum,
   output logic [63:0]                    rsp_stat_min,
   output logic [63:0]                    rsp_stat_max,
   output logic [63:0]                    rsp_stat_over,
   output logic                           rsp_table_full
);
   import iolt_pkg::*;

   localparam int IW = $clog2(TRACK_ENTRIES);
   localparam int RW = 2 + 64;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_ENC  = 3'd2;
   localparam logic [2:0] S_DLY  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;

   logic [2:0]  state_ff, state_in;
   item_type    cur_ff;

   logic [TRACK_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0] dev_ff [TRACK_ENTRIES];
   logic [63:0] sec_ff [TRACK_ENTRIES];
   logic [31:0] len_ff [TRACK_ENTRIES];

   logic [TRACK_ENTRIES-1:0] hit_vec_ff, free_vec_ff, hit_vec;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, hit_idx, free_idx;
   logic          hit_found_ff, free_found_ff, hit_found, free_found;
   logic [63:0]   delay_ff;
   logic [1:0]    ent_stage_ff;

   logic [63:0] cnt_ff [4];
   logic [63:0] sum_ff [4];
   logic [63:0] min_ff [4];
   logic [63:0] max_ff [4];
   logic [63:0] ovr_ff [4];

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [RW-1:0] ram_rdata;

   logic        upd_stats, over, do_write;
   logic [2:0]  anomaly;
   logic [63:0] n_cnt, n_sum, n_min, n_max, n_ovr;
   logic [IW-1:0] wr_idx;
   logic [64:0] range_end;

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign range_end = {1'b0, cur_ff.sector} + {33'b0, cur_ff.sector_count};

   always_comb begin
      for (int k = 0; k < TRACK_ENTRIES; k++) begin
         hit_vec[k] = valid_ff[k] && (dev_ff[k] == cur_ff.device)
                      && ({1'b0, sec_ff[k]} < range_end)
                      && (({1'b0, sec_ff[k]} + {33'b0, len_ff[k]}) > {1'b0, cur_ff.sector});
      end
   end

   always_comb begin
      hit_idx    = '0;
      free_idx   = '0;
      hit_found  = 1'b0;
      free_found = 1'b0;
      for (int k = TRACK_ENTRIES - 1; k >= 0; k--) begin
         if (hit_vec_ff[k]) begin
            hit_idx   = IW'(k);
            hit_found = 1'b1;
         end
         if (free_vec_ff[k]) begin
            free_idx   = IW'(k);
            free_found = 1'b1;
         end
      end
   end

   iolt_ram #(.WIDTH(RW), .DEPTH(TRACK_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({cur_ff.stage, cur_ff.timestamp}),
      .rd_addr (hit_idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      upd_stats = (state_ff == S_UPD) && cur_ff.is_event && hit_found_ff;
      over      = (threshold != '0) && (delay_ff > {24'b0, threshold});
      anomaly   = ANOM_NONE;
      if (cur_ff.stage == STAGE_GETRQ) begin
         anomaly = ANOM_EXIST;
      end else if (ent_stage_ff != cur_ff.stage - 2'd1) begin
         anomaly = (cur_ff.stage == STAGE_ISSUE) ? ANOM_BYPASS : ANOM_LOST;
      end
      if (over) begin
         anomaly = ANOM_GREATER;
      end
      n_cnt = cnt_ff[cur_ff.stage];
      n_sum = sum_ff[cur_ff.stage];
      n_min = min_ff[cur_ff.stage];
      n_max = max_ff[cur_ff.stage];
      n_ovr = ovr_ff[cur_ff.stage];
      if (upd_stats) begin
         n_cnt = n_cnt + 64'd1;
         n_sum = n_sum + delay_ff;
         if (delay_ff < n_min) begin
            n_min = delay_ff;
         end
         if (delay_ff > n_max) begin
            n_max = delay_ff;
         end
         if (over) begin
            n_ovr = n_ovr + 64'd1;
         end
      end else if (cur_ff.command == CMD_CLEAR) begin
         n_cnt = '0;
         n_sum = '0;
         n_min = ALL_ONES;
         n_max = '0;
         n_ovr = '0;
      end
      wr_idx   = hit_found_ff ? hit_idx_ff : free_idx_ff;
      do_write = (state_ff == S_UPD) && cur_ff.is_event && (cur_ff.stage != STAGE_COMPLETE)
                 && (hit_found_ff || free_found_ff);
      ram_we    = do_write;
      ram_waddr = wr_idx;
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = q_item.is_event ? S_CMP : S_UPD;
            end
         end
         S_CMP: state_in = S_ENC;
         S_ENC: state_in = S_DLY;
         S_DLY: state_in = S_UPD;
         S_UPD: begin
            state_in = S_IDLE;
            if (do_write) begin
               valid_in[wr_idx] = 1'b1;
            end else if (upd_stats) begin
               valid_in[hit_idx_ff] = 1'b0;
            end
            if (!cur_ff.is_event && cur_ff.command == CMD_FLUSH) begin
               valid_in = '0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         rsp_valid <= 1'b0;
         for (int s = 0; s < 4; s++) begin
            cnt_ff[s] <= '0;
            sum_ff[s] <= '0;
            min_ff[s] <= ALL_ONES;
            max_ff[s] <= '0;
            ovr_ff[s] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         rsp_valid <= (state_ff == S_UPD);
         if (state_ff == S_UPD) begin
            if (cur_ff.command == CMD_CLEAR && !cur_ff.is_event) begin
               for (int s = 0; s < 4; s++) begin
                  cnt_ff[s] <= '0;
                  sum_ff[s] <= '0;
                  min_ff[s] <= ALL_ONES;
                  max_ff[s] <= '0;
                  ovr_ff[s] <= '0;
               end
            end else begin
               cnt_ff[cur_ff.stage] <= n_cnt;
               sum_ff[cur_ff.stage] <= n_sum;
               min_ff[cur_ff.stage] <= n_min;
               max_ff[cur_ff.stage] <= n_max;
               ovr_ff[cur_ff.stage] <= n_ovr;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (state_ff == S_CMP) begin
         hit_vec_ff  <= hit_vec;
         free_vec_ff <= ~valid_ff;
      end
      if (state_ff == S_ENC) begin
         hit_idx_ff    <= hit_idx;
         free_idx_ff   <= free_idx;
         hit_found_ff  <= hit_found;
         free_found_ff <= free_found;
      end
      if (state_ff == S_IDLE) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (state_ff == S_DLY) begin
         delay_ff     <= hit_found_ff ? (cur_ff.timestamp - ram_rdata[63:0]) : 64'd0;
         ent_stage_ff <= ram_rdata[RW-1:64];
      end
      if (do_write) begin
         dev_ff[wr_idx] <= cur_ff.device;
         sec_ff[wr_idx] <= cur_ff.sector;
         len_ff[wr_idx] <= cur_ff.sector_count;
      end
      if (state_ff == S_UPD) begin
         rsp_matched    <= upd_stats;
         rsp_anomaly    <= upd_stats ? anomaly : ANOM_NONE;
         rsp_delay      <= upd_stats ? delay_ff : 64'd0;
         rsp_stat_count <= n_cnt;
         rsp_stat_sum   <= n_sum;
         rsp_stat_min   <= n_min;
         rsp_stat_max   <= n_max;
         rsp_stat_over  <= n_ovr;
         rsp_table_full <= cur_ff.is_event && !hit_found_ff
                           && (cur_ff.stage != STAGE_COMPLETE) && !free_found_ff;
      end
   end
endmodule

// ----- sv/io_request_latency_tracker.sv -----
// Tracks I/O requests across get-request, insert, issue and complete. An item
// is taken when start is high and busy is low; a two-deep queue holds items
// while the back end works. An event item passes the back end steps in order
// (queue pop, parallel overlap compare, priority pick with entry memory read,
// delay subtract, statistics and entry update); a command item skips to the update. The
// result appears on the rsp_ ports for exactly one cycle with rsp_valid high
// and must be captured then: the receiver cannot stall it. Write the
// threshold only while the block is idle.
module io_request_latency_tracker #(
   parameter int TRACK_ENTRIES = iolt_pkg::TRACK_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [1:0]                    req_stage,
   input  logic [31:0]                   req_device,
   input  logic [63:0]                   req_sector,
   input  logic [31:0]                   req_sector_count,
   input  logic [63:0]                   req_timestamp,
   input  logic                          csr_write_enable,
   input  logic [iolt_pkg::THRESH_W-1:0] csr_write_data,
   output logic                          rsp_valid,
   output logic                          rsp_matched,
   output logic [2:0]                    rsp_anomaly,
   output logic [63:0]                   rsp_delay,
   output logic [63:0]                   rsp_stat_count,
   output logic [63:0]                   rsp_stat_sum,
   output logic [63:0]                   rsp_stat_min,
   output logic [63:0]                   rsp_stat_max,
   output logic [63:0]                   rsp_stat_over,
   output logic                          rsp_table_full
);
   import iolt_pkg::*;

   logic [THRESH_W-1:0] threshold_ff;
   logic     q_valid, q_pop;
   item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   iolt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_stage        (req_stage),
      .req_device       (req_device),
      .req_sector       (req_sector),
      .req_sector_count (req_sector_count),
      .req_timestamp    (req_timestamp),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   iolt_back #(.TRACK_ENTRIES(TRACK_ENTRIES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .threshold      (threshold_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_matched    (rsp_matched),
      .rsp_anomaly    (rsp_anomaly),
      .rsp_delay      (rsp_delay),
      .rsp_stat_count (rsp_stat_count),
      .rsp_stat_sum   (rsp_stat_sum),
      .rsp_stat_min   (rsp_stat_min),
      .rsp_stat_max   (rsp_stat_max),
      .rsp_stat_over  (rsp_stat_over),
      .rsp_table_full (rsp_table_full)
   );
endmodule

// ----- sv/iolt_checker.sv -----
`include "io_request_latency_tracker_macros.svh"

module iolt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_matched,
   input logic [2:0]  rsp_anomaly,
   input logic [63:0] rsp_delay,
   input logic        rsp_table_full
);
   import iolt_pkg::*;

   `IOLT_ASSERT_SAME(a_anom_needs_match, clock, reset, rsp_valid && !rsp_matched, rsp_anomaly == ANOM_NONE)
   `IOLT_ASSERT_SAME(a_delay_needs_match, clock, reset, rsp_valid && !rsp_matched, rsp_delay == 64'd0)
   `IOLT_ASSERT_SAME(a_full_no_match, clock, reset, rsp_valid && rsp_table_full, !rsp_matched)
   `IOLT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind io_request_latency_tracker iolt_checker u_iolt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_matched    (rsp_matched),
   .rsp_anomaly    (rsp_anomaly),
   .rsp_delay      (rsp_delay),
   .rsp_table_full (rsp_table_full)
);
